[src/run_and_chunk_reuse_finder_defines.svh]
`ifndef RUN_AND_CHUNK_REUSE_FINDER_DEFINES_SVH
`define RUN_AND_CHUNK_REUSE_FINDER_DEFINES_SVH

// same-cycle implication
`define RCRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcrf check failed");

// next-cycle implication
`define RCRF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcrf check failed");

`endif

[src/rcrf_pkg.sv]
package rcrf_pkg;

  localparam int CFG_W = 17;
  localparam int LIM_W = 12;
  localparam int FP_W  = 64;

  localparam logic [FP_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  // prime is 2^40 + 0x1b3
  localparam int              FNV_SHIFT = 40;
  localparam logic [8:0]      FNV_LO    = 9'h1b3;

  localparam logic [1:0] REG_MIN_RUN     = 2'd0;
  localparam logic [1:0] REG_CHUNK_BYTES = 2'd1;
  localparam logic [1:0] REG_INDEX_LIMIT = 2'd2;

  localparam logic [CFG_W-1:0] MIN_RUN_RST     = 17'd4;
  localparam logic [CFG_W-1:0] CHUNK_BYTES_RST = 17'd64;
  localparam logic [LIM_W-1:0] INDEX_LIMIT_RST = 12'd2048;

  localparam logic [1:0] KIND_RUN   = 2'd0;
  localparam logic [1:0] KIND_REUSE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] source_pos;
    logic [16:0] span;
    logic [7:0]  run_byte;
    logic        status;
    logic        last;
  } res_t;

endpackage

[src/run_and_chunk_reuse_finder.sv]
// Byte stream deduplicator: one byte per input transfer, stored in an on-chip byte
// memory. Runs of equal bytes of at least min_run_length are reported; each
// chunk_bytes chunk that does not end inside a run of at least max(min_run_length,
// chunk_bytes) bytes is FNV-1a hashed and looked up in a linear-probe slot memory,
// and adjacent hits merge into one reuse that is sent only after a byte compare
// against the store. A chunk boundary steps through the probe, then flushes and
// updates the pending reuse; a pending reuse that is flushed is compared byte by
// byte (both store read ports compare one byte pair per pass) and then sent. The
// final byte runs the end sequence. A stalled output that still holds a result
// holds up this processing. After reset and after every end item the slot memory
// is cleared one slot per cycle while in_ready stays low. STORE_BYTES and
// TABLE_SLOTS must be powers of two.
module run_and_chunk_reuse_finder
  import rcrf_pkg::*;
#(
  parameter int STORE_BYTES = 65536,
  parameter int TABLE_SLOTS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int TW = $clog2(TABLE_SLOTS);
  localparam int PW = AW + 1;
  localparam int LW = (PW > CFG_W) ? PW : CFG_W;
  localparam int SW = 1 + FP_W + AW;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_RUN      = 13'b0000000000010,
    S_PROBE_RD = 13'b0000000000100,
    S_PROBE_CK = 13'b0000000001000,
    S_FL_START = 13'b0000000010000,
    S_FL_RD    = 13'b0000000100000,
    S_FL_CK    = 13'b0000001000000,
    S_FL_EMIT  = 13'b0000010000000,
    S_AFTER    = 13'b0000100000000,
    S_FIN_RUN  = 13'b0001000000000,
    S_FIN_END  = 13'b0010000000000,
    S_DONE     = 13'b0100000000000,
    S_CLEAR    = 13'b1000000000000
  } state_t;

  typedef enum logic [1:0] {
    AF_NONE, AF_SETPEND, AF_INSERT, AF_FIN
  } after_t;

  state_t           state;
  after_t           af;

  logic [CFG_W-1:0] min_run_length;
  logic [CFG_W-1:0] chunk_bytes;
  logic [LIM_W-1:0] index_limit;

  in_t              in_q;
  logic [PW-1:0]    position;
  logic [AW-1:0]    cur_run_start;
  logic [PW-1:0]    cur_run_len;
  logic [7:0]       cur_run_byte;
  logic [FP_W-1:0]  running_hash;
  logic [CFG_W-1:0] chunk_fill;
  logic             pend_valid;
  logic [AW-1:0]    pend_source;
  logic [AW-1:0]    pend_target;
  logic [PW-1:0]    pend_len;
  logic [LIM_W-1:0] entry_count;
  logic             dropped;

  logic [FP_W-1:0]  fp_q;
  logic [AW-1:0]    start_q;
  logic [TW-1:0]    probe_pos;
  logic [TW-1:0]    probe_cnt;
  logic             probe_ok;
  logic [AW-1:0]    hit_src;
  logic [PW-1:0]    cmp_idx;
  logic [TW-1:0]    clr_cnt;

  res_t             hold;
  logic             hold_v;

  logic [7:0]       byte_store [STORE_BYTES];
  logic [SW-1:0]    slot_mem [TABLE_SLOTS];
  logic [7:0]       rd_a;
  logic [7:0]       rd_b;
  logic [SW-1:0]    slot_rd;

  logic [CFG_W-1:0] mr_eff, cb_eff, gate;
  logic [LIM_W-1:0] il_eff;
  logic [7:0]       v;
  logic             room;
  logic             run_emit;
  logic [PW-1:0]    len_new;
  logic [FP_W-1:0]  h1, hash_new;
  logic [CFG_W-1:0] fill_inc;
  logic             boundary;
  logic [AW-1:0]    start_calc;
  logic             slot_v;
  logic [FP_W-1:0]  slot_fp;
  logic [AW-1:0]    slot_off;
  logic             merge;
  logic [AW-1:0]    cmp_a, cmp_b;
  logic             fin_run_ok;
  logic             out_free, can_emit, em_req, em_fire, push_last;
  res_t             em_res, hold_last;
  logic             store_we, store_rd, slot_re, slot_we;
  logic [TW-1:0]    slot_waddr;
  logic [SW-1:0]    slot_wdata;

  always_comb begin
    mr_eff   = (min_run_length == '0) ? CFG_W'(1) : min_run_length;
    cb_eff   = (chunk_bytes == '0) ? CFG_W'(1) : chunk_bytes;
    il_eff   = (index_limit == '0) ? LIM_W'(1) : index_limit;
    gate     = (mr_eff > cb_eff) ? mr_eff : cb_eff;
    v        = in_q.byte_value;
    room     = position < PW'(STORE_BYTES);
    run_emit = (cur_run_len != '0) && (v != cur_run_byte) &&
               (LW'(cur_run_len) >= LW'(mr_eff));
    if (cur_run_len == '0 || v != cur_run_byte) begin
      len_new = PW'(1);
    end else begin
      len_new = cur_run_len + PW'(1);
    end
    h1         = running_hash ^ {56'b0, v};
    hash_new   = (h1 << FNV_SHIFT) + (h1 * FNV_LO);
    fill_inc   = chunk_fill + CFG_W'(1);
    boundary   = fill_inc >= cb_eff;
    start_calc = AW'(LW'(position) + LW'(1) - LW'(cb_eff));
    {slot_v, slot_fp, slot_off} = slot_rd;
    merge = pend_valid &&
            ((AW+2)'(pend_source) + (AW+2)'(pend_len) == (AW+2)'(slot_off)) &&
            ((AW+2)'(pend_target) + (AW+2)'(pend_len) == (AW+2)'(start_q));
    cmp_a      = AW'(PW'(pend_source) + cmp_idx);
    cmp_b      = AW'(PW'(pend_target) + cmp_idx);
    fin_run_ok = LW'(cur_run_len) >= LW'(mr_eff);
  end

  assign out_free = !out_valid || out_ready;
  assign can_emit = !hold_v || out_free;
  assign in_ready = state == S_IDLE;

  always_comb begin
    em_req = 1'b0;
    em_res = '0;
    unique case (state)
      S_RUN: begin
        em_req           = room && run_emit;
        em_res.kind      = KIND_RUN;
        em_res.start_pos = 16'(cur_run_start);
        em_res.span      = 17'(cur_run_len);
        em_res.run_byte  = cur_run_byte;
      end
      S_FL_EMIT: begin
        em_req            = 1'b1;
        em_res.kind       = KIND_REUSE;
        em_res.start_pos  = 16'(pend_target);
        em_res.source_pos = 16'(pend_source);
        em_res.span       = 17'(pend_len);
      end
      S_FIN_RUN: begin
        em_req           = fin_run_ok;
        em_res.kind      = KIND_RUN;
        em_res.start_pos = 16'(cur_run_start);
        em_res.span      = 17'(cur_run_len);
        em_res.run_byte  = cur_run_byte;
      end
      S_FIN_END: begin
        em_req        = 1'b1;
        em_res.kind   = KIND_END;
        em_res.status = dropped;
      end
      default: em_req = 1'b0;
    endcase
    em_fire        = em_req && can_emit;
    push_last      = (state == S_DONE) && hold_v && out_free;
    hold_last      = hold;
    hold_last.last = 1'b1;
  end

  always_comb begin
    store_we   = (state == S_RUN) && room;
    store_rd   = state == S_FL_RD;
    slot_re    = state == S_PROBE_RD;
    slot_we    = 1'b0;
    slot_waddr = probe_pos;
    slot_wdata = {1'b1, fp_q, start_q};
    if (state == S_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_cnt;
      slot_wdata = '0;
    end else if (state == S_AFTER && af == AF_INSERT && probe_ok &&
                 entry_count < il_eff) begin
      slot_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      byte_store[position[AW-1:0]] <= v;
    end
    if (store_rd) begin
      rd_a <= byte_store[cmp_a];
      rd_b <= byte_store[cmp_b];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd <= slot_mem[probe_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      af             <= AF_NONE;
      min_run_length <= MIN_RUN_RST;
      chunk_bytes    <= CHUNK_BYTES_RST;
      index_limit    <= INDEX_LIMIT_RST;
      position       <= '0;
      cur_run_start  <= '0;
      cur_run_len    <= '0;
      cur_run_byte   <= '0;
      running_hash   <= FNV_BASIS;
      chunk_fill     <= '0;
      pend_valid     <= 1'b0;
      pend_source    <= '0;
      pend_target    <= '0;
      pend_len       <= '0;
      entry_count    <= '0;
      dropped        <= 1'b0;
      clr_cnt        <= '0;
      hold_v         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_RUN:     min_run_length <= cfg_wdata;
          REG_CHUNK_BYTES: chunk_bytes    <= cfg_wdata;
          REG_INDEX_LIMIT: index_limit    <= cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end

      if (em_fire && hold_v) begin
        out_valid <= 1'b1;
        out_data  <= hold;
      end else if (push_last) begin
        out_valid <= 1'b1;
        out_data  <= hold_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (em_fire) begin
        hold   <= em_res;
        hold_v <= 1'b1;
      end
      if (push_last) begin
        hold_v <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_q  <= in_data;
            state <= S_RUN;
          end
        end

        S_RUN: begin
          if (!room) begin
            dropped <= 1'b1;
            af      <= AF_FIN;
            state   <= in_q.final_byte ? S_FL_START : S_DONE;
          end else begin
            position    <= position + PW'(1);
            cur_run_len <= len_new;
            if (len_new == PW'(1)) begin
              cur_run_start <= position[AW-1:0];
              cur_run_byte  <= v;
            end
            if (boundary) begin
              fp_q         <= hash_new;
              start_q      <= start_calc;
              running_hash <= FNV_BASIS;
              chunk_fill   <= '0;
              probe_pos    <= hash_new[TW-1:0];
              probe_cnt    <= '0;
              if (LW'(len_new) >= LW'(gate)) begin
                af    <= AF_NONE;
                state <= S_FL_START;
              end else begin
                state <= S_PROBE_RD;
              end
            end else begin
              running_hash <= hash_new;
              chunk_fill   <= fill_inc;
              af           <= AF_FIN;
              state        <= in_q.final_byte ? S_FL_START : S_DONE;
            end
          end
        end

        S_PROBE_RD: state <= S_PROBE_CK;

        S_PROBE_CK: begin
          if (slot_v && slot_fp == fp_q) begin
            if (merge) begin
              pend_len <= PW'(LW'(pend_len) + LW'(cb_eff));
              af       <= AF_NONE;
              state    <= S_AFTER;
            end else begin
              hit_src <= slot_off;
              af      <= AF_SETPEND;
              state   <= S_FL_START;
            end
          end else if (!slot_v) begin
            probe_ok <= 1'b1;
            af       <= AF_INSERT;
            state    <= S_FL_START;
          end else if (probe_cnt == TW'(TABLE_SLOTS - 1)) begin
            probe_ok <= 1'b0;
            af       <= AF_INSERT;
            state    <= S_FL_START;
          end else begin
            probe_pos <= probe_pos + TW'(1);
            probe_cnt <= probe_cnt + TW'(1);
            state     <= S_PROBE_RD;
          end
        end

        S_FL_START: begin
          cmp_idx <= '0;
          if (pend_valid && pend_len != '0) begin
            state <= S_FL_RD;
          end else begin
            pend_valid <= 1'b0;
            pend_len   <= '0;
            state      <= S_AFTER;
          end
        end

        S_FL_RD: state <= S_FL_CK;

        S_FL_CK: begin
          if (rd_a != rd_b) begin
            pend_valid <= 1'b0;
            pend_len   <= '0;
            state      <= S_AFTER;
          end else if (cmp_idx + PW'(1) == pend_len) begin
            state <= S_FL_EMIT;
          end else begin
            cmp_idx <= cmp_idx + PW'(1);
            state   <= S_FL_RD;
          end
        end

        S_FL_EMIT: begin
          if (can_emit) begin
            pend_valid <= 1'b0;
            pend_len   <= '0;
            state      <= S_AFTER;
          end
        end

        S_AFTER: begin
          unique case (af)
            AF_NONE: begin
              af    <= AF_FIN;
              state <= in_q.final_byte ? S_FL_START : S_DONE;
            end
            AF_SETPEND: begin
              pend_valid  <= 1'b1;
              pend_source <= hit_src;
              pend_target <= start_q;
              pend_len    <= PW'(cb_eff);
              af          <= AF_FIN;
              state       <= in_q.final_byte ? S_FL_START : S_DONE;
            end
            AF_INSERT: begin
              if (slot_we) begin
                entry_count <= entry_count + LIM_W'(1);
              end
              af    <= AF_FIN;
              state <= in_q.final_byte ? S_FL_START : S_DONE;
            end
            AF_FIN: state <= S_FIN_RUN;
            default: state <= S_DONE;
          endcase
        end

        S_FIN_RUN: begin
          if (!fin_run_ok || can_emit) begin
            state <= S_FIN_END;
          end
        end

        S_FIN_END: begin
          if (can_emit) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!hold_v || out_free) begin
            if (in_q.final_byte) begin
              position      <= '0;
              cur_run_start <= '0;
              cur_run_len   <= '0;
              cur_run_byte  <= '0;
              running_hash  <= FNV_BASIS;
              chunk_fill    <= '0;
              pend_valid    <= 1'b0;
              pend_source   <= '0;
              pend_target   <= '0;
              pend_len      <= '0;
              entry_count   <= '0;
              dropped       <= 1'b0;
              clr_cnt       <= '0;
              state         <= S_CLEAR;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_CLEAR: begin
          clr_cnt <= clr_cnt + TW'(1);
          if (clr_cnt == TW'(TABLE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/rcrf_checker.sv]
`include "run_and_chunk_reuse_finder_defines.svh"

module rcrf_checker
  import rcrf_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input res_t out_data
);

  `RCRF_ASSERT_NOW(a_kind_legal, out_valid, out_data.kind != 2'd3)
  `RCRF_ASSERT_NOW(a_end_is_last, out_valid && out_data.kind == KIND_END, out_data.last)
  `RCRF_ASSERT_NOW(a_status_end_only, out_valid && out_data.kind != KIND_END,
                   !out_data.status)
  `RCRF_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `RCRF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind run_and_chunk_reuse_finder rcrf_checker u_rcrf_checker (.*);
